// ----- hw/rtl/pattern_word_filter_macros.svh -----
// Assertion helpers for the word filter.
`ifndef PATTERN_WORD_FILTER_MACROS_SVH
`define PATTERN_WORD_FILTER_MACROS_SVH

// Same-cycle implication, ignored while reset is asserted.
`define PWF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, ignored while reset is asserted.
`define PWF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/pwf_pkg.sv -----
`default_nettype none

package pwf_pkg;

    localparam int DEF_MAX_WORD_LEN = 32;

    localparam int LETTERS   = 26;
    localparam int LETTER_W  = 5;
    localparam int LTR_SLOTS = 2 ** LETTER_W;
    localparam int MASK_W    = 26;
    localparam int MASK_SLOTS = 32;
    localparam int MASK_AW   = $clog2(MASK_SLOTS);
    localparam int COUNT_W   = 6;
    localparam int LEN_W     = 6;
    localparam int MATCH_W   = 16;
    localparam int ACT_W     = 2;
    localparam int TALLY_W   = $clog2(LETTERS + 1);

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [MATCH_W-1:0] MATCH_MAX = '1;

    // Item actions
    localparam logic [ACT_W-1:0] ACT_BEGIN = 2'd0;
    localparam logic [ACT_W-1:0] ACT_MASK  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_COUNT = 2'd2;
    localparam logic [ACT_W-1:0] ACT_WORD  = 2'd3;

    // Register file
    localparam int APB_DW    = 32;
    localparam int REG_IDX_W = 1;
    localparam int APB_AW    = REG_IDX_W + 2;
    localparam logic [REG_IDX_W-1:0] REG_EXCLUDED = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_LIMIT    = 1'b1;

    typedef struct packed {
        logic [COUNT_W-1:0] need;
        logic [COUNT_W-1:0] seen;
    } t_ltr_data;

    typedef struct packed {
        logic                rd_en;
        logic [LETTER_W-1:0] rd_addr;
        logic                wr_en;
        logic [LETTER_W-1:0] wr_addr;
        t_ltr_data           wr_data;
        logic                clr_need;
        logic                clr_seen;
    } t_ltr_ctl;

    typedef struct packed {
        logic               clr;
        logic               wr_en;
        logic [MASK_AW-1:0] wr_addr;
        logic [MASK_W-1:0]  wr_data;
        logic [MASK_AW-1:0] rd_addr;
    } t_mask_ctl;

endpackage

`default_nettype wire

// ----- hw/rtl/pattern_word_filter.sv -----
// Word filter: one item per cycle unless the result output stalls, input and
// output both registered. A final word letter is taken into the execute stage,
// and its result beat then leaves from the output register.
// Throughput is set by the letter-count memory read-modify-write, forwarded
// so that back-to-back letters to the same entry need no stall.
// Reset is synchronous, active low; stores use valid bits, no clearing pass.
`default_nettype none

`include "pattern_word_filter_macros.svh"

module pattern_word_filter
    import pwf_pkg::*;
#(
    parameter int MAX_WORD_LEN = DEF_MAX_WORD_LEN
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // Item channel
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic [ACT_W-1:0]   i_action,
    input  wire logic [MASK_AW-1:0] i_position,
    input  wire logic [MASK_W-1:0]  i_allowed_mask,
    input  wire logic [LETTER_W-1:0] i_letter,
    input  wire logic [COUNT_W-1:0] i_required_count,
    input  wire logic [LEN_W-1:0]   i_pattern_length,
    input  wire logic               i_last_letter,
    // Result channel
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic                    o_accepted,
    output logic      [MATCH_W-1:0] o_matches_so_far,
    output logic                    o_limit_reached,
    // Register port
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [APB_AW-1:0]  paddr,
    input  wire logic [APB_DW-1:0]  pwdata,
    output logic      [APB_DW-1:0]  prdata,
    output logic                    pready
);

    localparam int IDX_W = $clog2(MAX_WORD_LEN + 1);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [MASK_W-1:0]  cfg_excluded;
    logic [MATCH_W-1:0] cfg_limit;

    pwf_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .o_excluded (cfg_excluded),
        .o_limit    (cfg_limit)
    );

    // ------------------------------------------------------------------
    // Execute stage: holds the beat while the memories deliver its data
    // ------------------------------------------------------------------
    logic                r_s1_vld;
    logic [ACT_W-1:0]    r_s1_action;
    logic [MASK_AW-1:0]  r_s1_position;
    logic [MASK_W-1:0]   r_s1_allowed;
    logic [LETTER_W-1:0] r_s1_letter;
    logic [COUNT_W-1:0]  r_s1_required;
    logic [LEN_W-1:0]    r_s1_plen;
    logic                r_s1_last;

    // Query and word state kept in flops
    logic [LEN_W-1:0]    r_target,   n_target;
    logic [IDX_W-1:0]    r_idx,      n_idx;
    logic                r_failed,   n_failed;
    logic [TALLY_W-1:0]  r_deficit,  n_deficit;   // letters still short of their count
    logic [TALLY_W-1:0]  r_nz_need,  n_nz_need;   // letters with a nonzero requirement
    logic [MATCH_W-1:0]  r_accept_count, n_accept_count;

    // Output register
    logic                r_out_vld;
    logic                r_out_accepted;
    logic [MATCH_W-1:0]  r_out_matches;
    logic                r_out_limit;

    logic                s1_has_out;
    logic                s1_go;
    logic                in_acc;

    t_mask_ctl           mask_ctl;
    t_ltr_ctl            ltr_ctl;
    logic [MASK_W-1:0]   mask_q;
    t_ltr_data           ltr_q;

    logic                letter_ok;
    logic [MASK_W-1:0]   letter_bit;
    logic                idx_ok;
    logic                in_slot;
    logic                mask_miss;
    logic                excl_hit;
    logic [COUNT_W-1:0]  seen_inc;
    logic                limit_pre;
    logic                word_ok;
    logic                limit_post;
    logic                old_short;
    logic                new_short;

    assign s1_has_out = (r_s1_action == ACT_WORD) && r_s1_last;
    // Advance unless a result beat would land on a full, stalled output.
    assign s1_go      = r_s1_vld && (!s1_has_out || !r_out_vld || i_out_ready);
    assign o_in_ready = !r_s1_vld || s1_go;
    assign in_acc     = i_in_valid && o_in_ready;

    // Per-letter checks
    assign letter_ok  = 32'(r_s1_letter) < 32'(LETTERS);
    assign letter_bit = letter_ok ? (MASK_W'(1) << r_s1_letter) : '0;
    assign idx_ok     = 32'(r_idx) < 32'(MAX_WORD_LEN);
    assign in_slot    = 32'(r_idx) < 32'(MASK_SLOTS);
    assign mask_miss  = in_slot && (mask_q != '0) && ((mask_q & letter_bit) == '0);
    assign excl_hit   = (cfg_excluded & letter_bit) != '0;
    assign seen_inc   = (ltr_q.seen == COUNT_MAX) ? ltr_q.seen : ltr_q.seen + 1'b1;
    assign limit_pre  = (cfg_limit != '0) && (r_accept_count >= cfg_limit);
    assign limit_post = (cfg_limit != '0) && (n_accept_count >= cfg_limit);

    always_comb begin
        n_target       = r_target;
        n_idx          = r_idx;
        n_failed       = r_failed;
        n_deficit      = r_deficit;
        n_nz_need      = r_nz_need;
        n_accept_count = r_accept_count;
        word_ok        = 1'b0;
        old_short      = ltr_q.seen < ltr_q.need;
        new_short      = ltr_q.seen < r_s1_required;

        ltr_ctl.rd_en    = in_acc;
        ltr_ctl.rd_addr  = i_letter;
        ltr_ctl.wr_en    = 1'b0;
        ltr_ctl.wr_addr  = r_s1_letter;
        ltr_ctl.wr_data  = ltr_q;
        ltr_ctl.clr_need = 1'b0;
        ltr_ctl.clr_seen = 1'b0;

        mask_ctl.clr     = 1'b0;
        mask_ctl.wr_en   = 1'b0;
        mask_ctl.wr_addr = r_s1_position;
        mask_ctl.wr_data = r_s1_allowed;

        if (s1_go) begin
            unique case (r_s1_action)
                ACT_BEGIN: begin
                    // Fresh query: wildcard every position, drop counts and word
                    n_target         = r_s1_plen;
                    n_idx            = '0;
                    n_failed         = 1'b0;
                    n_deficit        = '0;
                    n_nz_need        = '0;
                    n_accept_count   = '0;
                    mask_ctl.clr     = 1'b1;
                    ltr_ctl.clr_need = 1'b1;
                    ltr_ctl.clr_seen = 1'b1;
                end
                ACT_MASK: begin
                    mask_ctl.wr_en = 1'b1;
                end
                ACT_COUNT: begin
                    if (letter_ok) begin
                        ltr_ctl.wr_en        = 1'b1;
                        ltr_ctl.wr_data.need = r_s1_required;
                        n_deficit = r_deficit + TALLY_W'(new_short) - TALLY_W'(old_short);
                        n_nz_need = r_nz_need + TALLY_W'(r_s1_required != '0)
                                  - TALLY_W'(ltr_q.need != '0);
                    end
                end
                ACT_WORD: begin
                    if (!idx_ok) begin
                        // Too long: fail and hold the index at its ceiling
                        n_failed = 1'b1;
                    end else begin
                        if (!letter_ok || mask_miss || excl_hit) begin
                            n_failed = 1'b1;
                        end
                        if (letter_ok) begin
                            ltr_ctl.wr_en        = 1'b1;
                            ltr_ctl.wr_data.seen = seen_inc;
                            if (old_short && !(seen_inc < ltr_q.need)) begin
                                n_deficit = r_deficit - TALLY_W'(1);
                            end
                        end
                        n_idx = r_idx + IDX_W'(1);
                    end
                    if (r_s1_last) begin
                        word_ok = !n_failed && (32'(n_idx) == 32'(r_target))
                                && !limit_pre && (n_deficit == '0);
                        if (word_ok && (r_accept_count != MATCH_MAX)) begin
                            n_accept_count = r_accept_count + MATCH_W'(1);
                        end
                        // Word done: every seen count drops back to zero
                        n_idx            = '0;
                        n_failed         = 1'b0;
                        n_deficit        = n_nz_need;
                        ltr_ctl.clr_seen = 1'b1;
                    end
                end
            endcase
        end

        // Fetch the mask for whichever position the next letter will hit
        mask_ctl.rd_addr = MASK_AW'(n_idx);
    end

    pwf_mask_mem u_mask_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (mask_ctl),
        .o_mask  (mask_q)
    );

    pwf_ltr_mem u_ltr_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ltr_ctl),
        .o_rd    (ltr_q)
    );

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld       <= 1'b0;
            r_target       <= '0;
            r_idx          <= '0;
            r_failed       <= 1'b0;
            r_deficit      <= '0;
            r_nz_need      <= '0;
            r_accept_count <= '0;
            r_out_vld      <= 1'b0;
        end else begin
            r_s1_vld       <= in_acc || (r_s1_vld && !s1_go);
            r_target       <= n_target;
            r_idx          <= n_idx;
            r_failed       <= n_failed;
            r_deficit      <= n_deficit;
            r_nz_need      <= n_nz_need;
            r_accept_count <= n_accept_count;
            if (s1_go && s1_has_out) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Payload: capture the beat on accept, the result when it retires
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_action   <= i_action;
            r_s1_position <= i_position;
            r_s1_allowed  <= i_allowed_mask;
            r_s1_letter   <= i_letter;
            r_s1_required <= i_required_count;
            r_s1_plen     <= i_pattern_length;
            r_s1_last     <= i_last_letter;
        end
        if (s1_go && s1_has_out) begin
            r_out_accepted <= word_ok;
            r_out_matches  <= n_accept_count;
            r_out_limit    <= limit_post;
        end
    end

    assign o_out_valid      = r_out_vld;
    assign o_accepted       = r_out_accepted;
    assign o_matches_so_far = r_out_matches;
    assign o_limit_reached  = r_out_limit;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `PWF_ASSERT_NOW(a_deficit_bound, i_clk, i_rst_n, 1'b1, r_deficit <= r_nz_need, "deficit exceeds required letters")
    `PWF_ASSERT_NOW(a_idx_bound, i_clk, i_rst_n, 1'b1, 32'(r_idx) <= 32'(MAX_WORD_LEN), "letter index past ceiling")
    `PWF_ASSERT_NOW(a_accept_count, i_clk, i_rst_n, o_out_valid && o_accepted, o_matches_so_far != '0, "accepted word with zero match count")
    `PWF_ASSERT_NEXT(a_begin_clears, i_clk, i_rst_n, s1_go && (r_s1_action == ACT_BEGIN), (r_deficit == '0) && (r_accept_count == '0) && (r_idx == '0), "begin query left stale state")

endmodule

`default_nettype wire

// ----- hw/rtl/pwf_cfg.sv -----
`default_nettype none

module pwf_cfg
    import pwf_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready,
    output logic      [MASK_W-1:0] o_excluded,
    output logic     [MATCH_W-1:0] o_limit
);

    logic [MASK_W-1:0]    r_excluded;
    logic [MATCH_W-1:0]   r_limit;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_hit;

    assign reg_idx = paddr[APB_AW-1:2];
    assign wr_hit  = psel && penable && pwrite && pready;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_excluded <= '0;
            r_limit    <= '0;
        end else if (wr_hit) begin
            unique case (reg_idx)
                REG_EXCLUDED: r_excluded <= pwdata[MASK_W-1:0];
                REG_LIMIT:    r_limit    <= pwdata[MATCH_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_EXCLUDED: prdata = APB_DW'(r_excluded);
            REG_LIMIT:    prdata = APB_DW'(r_limit);
        endcase
    end

    assign o_excluded = r_excluded;
    assign o_limit    = r_limit;

endmodule

`default_nettype wire

// ----- hw/rtl/pwf_mask_mem.sv -----
`default_nettype none

module pwf_mask_mem
    import pwf_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_mask_ctl         i_ctl,
    output logic      [MASK_W-1:0] o_mask
);

    logic [MASK_W-1:0]     r_mem [MASK_SLOTS];
    logic [MASK_W-1:0]     r_raw;
    logic [MASK_W-1:0]     r_byp_data;
    logic                  r_use_mem;
    logic [MASK_SLOTS-1:0] r_vld;
    logic [MASK_SLOTS-1:0] n_vld;
    logic                  same_addr;

    assign same_addr = i_ctl.wr_en && (i_ctl.wr_addr == i_ctl.rd_addr);

    always_comb begin
        n_vld = r_vld;
        if (i_ctl.clr) begin
            n_vld = '0;
        end else if (i_ctl.wr_en) begin
            n_vld = r_vld | (MASK_SLOTS'(1) << i_ctl.wr_addr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    // Read every cycle; a write or clear landing on the same edge wins.
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_ctl.wr_addr] <= i_ctl.wr_data;
        end
        r_raw      <= r_mem[i_ctl.rd_addr];
        r_use_mem  <= !i_ctl.clr && !same_addr && r_vld[i_ctl.rd_addr];
        r_byp_data <= (same_addr && !i_ctl.clr) ? i_ctl.wr_data : '0;
    end

    assign o_mask = r_use_mem ? r_raw : r_byp_data;

endmodule

`default_nettype wire

// ----- hw/rtl/pwf_ltr_mem.sv -----
`default_nettype none

module pwf_ltr_mem
    import pwf_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_ltr_ctl  i_ctl,
    output t_ltr_data      o_rd
);

    t_ltr_data            r_mem [LTR_SLOTS];
    t_ltr_data            r_raw;
    t_ltr_data            r_byp_data;
    t_ltr_data            rd_data;
    logic                 r_byp;
    logic [LETTER_W-1:0]  r_rd_addr;
    logic [LTR_SLOTS-1:0] r_need_vld;
    logic [LTR_SLOTS-1:0] r_seen_vld;
    logic [LTR_SLOTS-1:0] n_need_vld;
    logic [LTR_SLOTS-1:0] n_seen_vld;
    logic [LTR_SLOTS-1:0] wr_sel;

    assign wr_sel = i_ctl.wr_en ? (LTR_SLOTS'(1) << i_ctl.wr_addr) : '0;

    always_comb begin
        n_need_vld = i_ctl.clr_need ? '0 : (r_need_vld | wr_sel);
        n_seen_vld = i_ctl.clr_seen ? '0 : (r_seen_vld | wr_sel);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_need_vld <= '0;
            r_seen_vld <= '0;
        end else begin
            r_need_vld <= n_need_vld;
            r_seen_vld <= n_seen_vld;
        end
    end

    // Hold the read until the next accepted beat; forward a same-edge write.
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_ctl.wr_addr] <= i_ctl.wr_data;
        end
        if (i_ctl.rd_en) begin
            r_raw      <= r_mem[i_ctl.rd_addr];
            r_byp      <= i_ctl.wr_en && (i_ctl.wr_addr == i_ctl.rd_addr);
            r_byp_data <= i_ctl.wr_data;
            r_rd_addr  <= i_ctl.rd_addr;
        end
    end

    assign rd_data   = r_byp ? r_byp_data : r_raw;
    assign o_rd.need = r_need_vld[r_rd_addr] ? rd_data.need : '0;
    assign o_rd.seen = r_seen_vld[r_rd_addr] ? rd_data.seen : '0;

endmodule

`default_nettype wire
